FILE: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package deq_pkg;

  // Number of cells in the chain, legal range 2 to 64.
  localparam int unsigned DEPTH       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // A list reports at most this many elements.
  localparam logic [CNT_W-1:0] LIST_CAP =
    (DEPTH < MAX_RESULTS) ? CNT_W'(DEPTH) : CNT_W'(MAX_RESULTS);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_POPPED = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_LISTED = 3'd4
  } status_e;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_SHIFT_UP   = 3'd1,  // push front: cell i takes cell i-1
    OP_WRITE_TAIL = 3'd2,  // push rear: cell at the occupancy takes the word
    OP_SHIFT_DOWN = 3'd3,  // pop front: cell i takes cell i+1
    OP_ROTATE     = 3'd4   // list step: shift down, tail takes the head
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    cnt_t     occ;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/deq_cmd_if.sv
// Command channel of the double-ended queue: valid/ready plus cmd and value.
// Depends on deq_pkg.
`default_nettype none

interface deq_cmd_if;
  logic          valid;
  logic          ready;
  logic [2:0]    cmd;
  deq_pkg::data_t value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/deq_res_if.sv
// Result channel of the double-ended queue: valid/ready plus status,
// item_value and last. Depends on deq_pkg.
`default_nettype none

interface deq_res_if;
  logic           valid;
  logic           ready;
  logic [2:0]     status;
  deq_pkg::data_t item_value;
  logic           last;

  modport source (output valid, output status, output item_value, output last,
                  input ready);
  modport sink   (input valid, input status, input item_value, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/deq_cell.sv
// One storage cell of the queue chain; takes a word from a neighbor,
// from the push input or from the head, as the broadcast control says.
// Depends on deq_pkg.
`default_nettype none

module deq_cell (
  input  logic                clk_i,
  input  deq_pkg::cell_ctrl_t ctrl_i,
  input  deq_pkg::cnt_t       idx_i,
  input  deq_pkg::data_t      push_val_i,
  input  deq_pkg::data_t      left_val_i,
  input  deq_pkg::data_t      right_val_i,
  input  deq_pkg::data_t      head_val_i,
  output deq_pkg::data_t      val_o
);

  deq_pkg::data_t val_d, val_q;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      deq_pkg::OP_SHIFT_UP: begin
        val_d = left_val_i;
      end
      deq_pkg::OP_WRITE_TAIL: begin
        if (idx_i == ctrl_i.occ) begin
          val_d = push_val_i;
        end
      end
      deq_pkg::OP_SHIFT_DOWN: begin
        val_d = right_val_i;
      end
      deq_pkg::OP_ROTATE: begin
        if ((idx_i + deq_pkg::CNT_W'(1)) == ctrl_i.occ) begin
          val_d = head_val_i;
        end else begin
          val_d = right_val_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

FILE: hdl/double_ended_queue.sv
// Top level of the double-ended queue: command decode, list sequencer,
// output register and the chain of deq_cell storage cells.
// Depends on deq_pkg, deq_cmd_if, deq_res_if and deq_cell.
`default_nettype none

// The queue keeps its elements in a row of DEPTH cells, in order from the
// front (cell 0) to the rear (cell occupancy-1), so no ring pointers are
// needed. A push at the front shifts the whole row up by one cell and a pop
// at the front shifts it down; a push at the rear writes the cell at the
// occupancy and a pop at the rear reads the cell just below it. Each push or
// pop command answers with one result word in the next cycle; a new command
// is taken as soon as the output register is empty or its word is being
// taken, so pushes and pops run at one word per cycle when the result side
// keeps up. A list command rotates the row one cell per cycle while it is
// not held, reading the front cell each time, and makes occupancy rotations
// after it is accepted; while it runs no command is taken. The first
// min(occupancy, 16) rotations each emit one listed word, the last of them
// marked, and such a rotation waits while the output register is full and
// its word is not being taken. After a full turn the row is back in its
// original order. A list, pop or push that finds nothing to do answers with
// a single empty or full-refused word, and an unused command code is dropped
// without a result. The cells hold no reset value; only occupied cells are
// ever read, so no clearing is needed after reset.
module double_ended_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_cmd_if.sink    cmd_i,
  deq_res_if.source  res_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e state_d, state_q;
  deq_pkg::cnt_t occ_d, occ_q;
  deq_pkg::cnt_t step_d, step_q;  // rotations done in the current list

  logic           out_valid_d, out_valid_q;
  logic [2:0]     out_status_d, out_status_q;
  deq_pkg::data_t out_value_d, out_value_q;
  logic           out_last_d, out_last_q;

  deq_pkg::cell_ctrl_t ctrl;
  deq_pkg::data_t      cell_val [deq_pkg::DEPTH];

  logic          out_free;
  logic          cmd_acc;
  deq_pkg::cnt_t occ_m1;
  deq_pkg::cnt_t list_n;
  logic          list_emit;
  logic          list_step;

  assign out_free    = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == S_IDLE) && out_free;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign occ_m1      = occ_q - deq_pkg::CNT_W'(1);

  // Number of words the current list reports.
  assign list_n    = (occ_q < deq_pkg::LIST_CAP) ? occ_q : deq_pkg::LIST_CAP;
  assign list_emit = step_q < deq_pkg::LIST_CAP;
  // Rotations past the report limit need no output slot.
  assign list_step = (state_q == S_LIST) && (!list_emit || out_free);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    ctrl.op      = deq_pkg::OP_HOLD;
    ctrl.occ     = occ_q;

    if (cmd_acc) begin
      case (cmd_i.cmd)
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_REAR: begin
          out_valid_d = 1'b1;
          out_value_d = '0;
          out_last_d  = 1'b1;
          if (occ_q == deq_pkg::FULL_CNT) begin
            out_status_d = deq_pkg::ST_FULL;
          end else begin
            out_status_d = deq_pkg::ST_PUSHED;
            occ_d        = occ_q + deq_pkg::CNT_W'(1);
            ctrl.op      = (cmd_i.cmd == deq_pkg::CMD_PUSH_FRONT) ?
                           deq_pkg::OP_SHIFT_UP : deq_pkg::OP_WRITE_TAIL;
          end
        end
        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_REAR: begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (occ_q == '0) begin
            out_status_d = deq_pkg::ST_EMPTY;
            out_value_d  = '0;
          end else begin
            out_status_d = deq_pkg::ST_POPPED;
            occ_d        = occ_m1;
            if (cmd_i.cmd == deq_pkg::CMD_POP_FRONT) begin
              out_value_d = cell_val[0];
              ctrl.op     = deq_pkg::OP_SHIFT_DOWN;
            end else begin
              out_value_d = cell_val[occ_m1[deq_pkg::IDX_W-1:0]];
            end
          end
        end
        deq_pkg::CMD_LIST: begin
          if (occ_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = deq_pkg::ST_EMPTY;
            out_value_d  = '0;
            out_last_d   = 1'b1;
          end else begin
            state_d = S_LIST;
            step_d  = '0;
          end
        end
        default: begin
          // Unused codes leave everything as it is.
        end
      endcase
    end else if (list_step) begin
      ctrl.op = deq_pkg::OP_ROTATE;
      if (list_emit) begin
        out_valid_d  = 1'b1;
        out_status_d = deq_pkg::ST_LISTED;
        out_value_d  = cell_val[0];
        out_last_d   = (step_q + deq_pkg::CNT_W'(1)) == list_n;
      end
      step_d = step_q + deq_pkg::CNT_W'(1);
      if (step_q == occ_m1) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_status_q;
  assign res_o.item_value = out_value_q;
  assign res_o.last       = out_last_q;

  // The chain of cells; cell 0 holds the front element.
  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    deq_pkg::data_t left_val;
    deq_pkg::data_t right_val;

    if (i == 0) begin : g_first
      assign left_val = cmd_i.value;
    end else begin : g_mid_l
      assign left_val = cell_val[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign right_val = cell_val[0];
    end else begin : g_mid_r
      assign right_val = cell_val[i+1];
    end

    deq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .idx_i       (deq_pkg::CNT_W'(i)),
      .push_val_i  (cmd_i.value),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .head_val_i  (cell_val[0]),
      .val_o       (cell_val[i])
    );
  end

`ifndef SYNTHESIS
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= deq_pkg::FULL_CNT)
    else $error("occupancy above depth");

  a_list_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |-> !cmd_i.ready)
    else $error("command taken during a list");

  a_list_keeps_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LIST |=> occ_q == $past(occ_q))
    else $error("list changed the occupancy");

  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_i.cmd == deq_pkg::CMD_PUSH_FRONT ||
                cmd_i.cmd == deq_pkg::CMD_PUSH_REAR ||
                cmd_i.cmd == deq_pkg::CMD_POP_FRONT ||
                cmd_i.cmd == deq_pkg::CMD_POP_REAR)
    |=> out_valid_q && out_last_q)
    else $error("push or pop gave no final result");

  a_list_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && cmd_i.cmd == deq_pkg::CMD_LIST && occ_q != '0 |=> state_q == S_LIST)
    else $error("list of a filled queue did not start");
`endif

endmodule

`default_nettype wire
